// ===== rtl/range_overlap_table_lookup_defines.svh =====
// Assertion macros for the range overlap table lookup checker.
// Depends on nothing; the checker includes this header.
`ifndef RANGE_OVERLAP_TABLE_LOOKUP_DEFINES_SVH
`define RANGE_OVERLAP_TABLE_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ROL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ROL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rol_pkg.sv =====
// Shared constants, types and helper functions of the range overlap table lookup.
// Depends on nothing; every other file but the defines header imports it.
package rol_pkg;

    // Table geometry and field widths.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 64;
    localparam int SLOT_W        = 4;
    localparam int STATUS_W      = 2;

    // Operation codes of an input beat.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONTAINED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Write port of the table.
    typedef struct packed {
        logic  en;
        idx_t  addr;
        addr_t lo;
        addr_t hi;
        logic  mark;
    } wr_t;

    // One entry as read back from the table.
    typedef struct packed {
        logic  mark;
        addr_t lo;
        addr_t hi;
    } entry_t;

    // Controls from the sequencer to the scan datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic pick;
    } scan_ctl_t;

    // Result of one item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } res_t;

    // True when a slot number addresses an existing entry.
    function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, slot};
        return ext < (IDX_W + SLOT_W)'(TABLE_ENTRIES);
    endfunction

    // Table address taken from a slot number.
    function automatic idx_t slot_to_idx(input logic [SLOT_W-1:0] slot);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, slot};
        return ext[IDX_W-1:0];
    endfunction

    // Slot number reported for a table address, kept to the low slot bits.
    function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/rol_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on rol_pkg for field widths.
interface rol_in_if import rol_pkg::*;;
    logic                valid;
    logic                ready;
    logic                op;
    logic [ADDR_W-1:0]   range_start;
    logic [ADDR_W-1:0]   range_end;
    logic [SLOT_W-1:0]   slot;
    logic                slot_valid;

    modport source (output valid, op, range_start, range_end, slot, slot_valid,
                    input ready);
    modport sink   (input valid, op, range_start, range_end, slot, slot_valid,
                    output ready);
endinterface

interface rol_out_if import rol_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   hit_slot;

    modport source (output valid, status, hit_slot, input ready);
    modport sink   (input valid, status, hit_slot, output ready);
endinterface

// ===== rtl/rol_table.sv =====
// Range table storage: one synchronous memory for start and end, plus valid flags.
// Depends on rol_pkg.
module rol_table
    import rol_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  wr_t    wr,
    input  logic   rd_en,
    input  idx_t   rd_addr,
    output entry_t rd_data
);

    logic [2*ADDR_W-1:0] mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [2*ADDR_W-1:0] rd_word_reg;
    logic                rd_mark_reg;

    // Start and end share one memory word; read data is registered.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.lo, wr.hi};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            rd_mark_reg <= valid_reg[rd_addr];
        end
    end

    // Valid flags clear at reset, so unwritten entries never take part in a scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= wr.mark;
        end
    end

    assign rd_data.mark = rd_mark_reg;
    assign rd_data.lo   = rd_word_reg[2*ADDR_W-1:ADDR_W];
    assign rd_data.hi   = rd_word_reg[ADDR_W-1:0];

endmodule

// ===== rtl/rol_scan.sv =====
// Scan datapath: tracks the nearest entries above and below the query start
// and the highest entry, then picks and judges one. Depends on rol_pkg.
module rol_scan
    import rol_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_ctl_t ctl,
    input  addr_t     query_start,
    input  addr_t     query_end,
    input  entry_t    entry,
    input  idx_t      entry_idx,
    output res_t      result
);

    typedef enum logic [1:0] {
        PK_NONE,
        PK_JUDGE,
        PK_OVERLAP
    } pick_kind_t;

    addr_t qs_reg, qe_reg;
    logic  have_any_reg, have_up_reg, have_down_reg;
    addr_t top_start_reg, up_start_reg, down_start_reg;
    addr_t top_end_reg, up_end_reg, down_end_reg;
    idx_t  top_idx_reg, up_idx_reg, down_idx_reg;

    pick_kind_t kind_next, kind_reg;
    idx_t       sel_idx_next, sel_idx_reg;
    addr_t      sel_end_next, sel_end_reg;

    logic take_top, take_up, take_down;
    addr_t s;

    // Per-entry compares; strict ordering keeps the lowest index on equal starts.
    always_comb
    begin
        s         = entry.lo;
        take_top  = !have_any_reg || (s > top_start_reg);
        take_up   = (s >= qs_reg) && (!have_up_reg || (s < up_start_reg));
        take_down = (s <= qs_reg) && (!have_down_reg || (s > down_start_reg));
    end

    // Presence flags of the three candidates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_any_reg  <= 1'b0;
            have_up_reg   <= 1'b0;
            have_down_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            have_any_reg  <= 1'b0;
            have_up_reg   <= 1'b0;
            have_down_reg <= 1'b0;
        end
        else if (ctl.load && entry.mark)
        begin
            have_any_reg <= 1'b1;
            if (take_up)
            begin
                have_up_reg <= 1'b1;
            end
            if (take_down)
            begin
                have_down_reg <= 1'b1;
            end
        end
    end

    // Query bounds and candidate payloads.
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            qs_reg <= query_start;
            qe_reg <= query_end;
        end
        if (ctl.load && entry.mark)
        begin
            if (take_top)
            begin
                top_start_reg <= s;
                top_end_reg   <= entry.hi;
                top_idx_reg   <= entry_idx;
            end
            if (take_up)
            begin
                up_start_reg <= s;
                up_end_reg   <= entry.hi;
                up_idx_reg   <= entry_idx;
            end
            if (take_down)
            begin
                down_start_reg <= s;
                down_end_reg   <= entry.hi;
                down_idx_reg   <= entry_idx;
            end
        end
        if (ctl.pick)
        begin
            kind_reg    <= kind_next;
            sel_idx_reg <= sel_idx_next;
            sel_end_reg <= sel_end_next;
        end
    end

    // Choose which entry decides the answer once the scan is complete.
    always_comb
    begin
        kind_next    = PK_NONE;
        sel_idx_next = up_idx_reg;
        sel_end_next = up_end_reg;
        if (!have_any_reg)
        begin
            kind_next = PK_NONE;
        end
        else if (!have_up_reg)
        begin
            kind_next    = PK_JUDGE;
            sel_idx_next = top_idx_reg;
            sel_end_next = top_end_reg;
        end
        else if (up_start_reg == qs_reg)
        begin
            kind_next = PK_JUDGE;
        end
        else if (qe_reg > up_start_reg)
        begin
            kind_next = PK_OVERLAP;
        end
        else if (!have_down_reg)
        begin
            kind_next = PK_NONE;
        end
        else
        begin
            kind_next    = PK_JUDGE;
            sel_idx_next = down_idx_reg;
            sel_end_next = down_end_reg;
        end
    end

    // Judge the query against the chosen entry's end, or report an overlap with it outright.
    always_comb
    begin
        result.status = ST_NONE;
        result.slot   = '0;
        case (kind_reg)
            PK_OVERLAP:
            begin
                result.status = ST_OVERLAP;
                result.slot   = idx_to_slot(sel_idx_reg);
            end
            PK_JUDGE:
            begin
                if (qe_reg <= sel_end_reg)
                begin
                    result.status = ST_CONTAINED;
                    result.slot   = idx_to_slot(sel_idx_reg);
                end
                else if (qs_reg < sel_end_reg)
                begin
                    result.status = ST_OVERLAP;
                    result.slot   = idx_to_slot(sel_idx_reg);
                end
            end
            default:
            begin
                result.status = ST_NONE;
                result.slot   = '0;
            end
        endcase
    end

endmodule

// ===== rtl/range_overlap_table_lookup.sv =====
// Range overlap table lookup: a table of address ranges that answers
// containment and overlap queries for a half-open range.
//
// Channels: req carries request beats (op, range_start, range_end, slot,
// slot_valid); rsp returns one beat (status, hit_slot) per request, in order.
// A write beat (op 0) stores start, end and valid mark in one entry; a slot
// beyond the table is ignored. A query beat (op 1) reads every entry in turn
// through the single read port of the table memory.
// Sequence: a write, or an empty or reversed query, goes from the accepting
// IDLE state straight to RESP, which loads the response register. Any other
// query steps through SCAN (one memory read per entry), DRAIN (the last read
// data), PICK (the deciding entry), JUDGE and RESP (which loads the response).
// The next request is taken in the cycle after the response register loads.
// Reset clears all valid marks, so the table starts empty; entry contents
// are not cleared. When the receiver stalls, the response holds in the
// output register and the next item is still accepted and worked on; its
// result waits until the register is free, and req stays low meanwhile.
module range_overlap_table_lookup
    import rol_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    rol_in_if.sink  req,
    rol_out_if.source rsp
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        DRAIN,
        PICK,
        JUDGE,
        RESP
    } state_t;

    state_t state_reg, state_next;
    idx_t   cnt_reg;
    logic   data_vld_reg;
    idx_t   data_idx_reg;
    res_t   res_reg;
    logic   out_valid_reg;
    res_t   out_reg;

    logic      accept;
    logic      out_free;
    wr_t       wr;
    scan_ctl_t ctl;
    entry_t    rd_data;
    res_t      scan_res;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // Table write happens in the cycle the write beat is accepted.
    assign wr.en   = accept && (req.op == OP_WRITE) && slot_in_range(req.slot);
    assign wr.addr = slot_to_idx(req.slot);
    assign wr.lo   = req.range_start;
    assign wr.hi   = req.range_end;
    assign wr.mark = req.slot_valid;

    assign ctl.clear = accept && (req.op == OP_QUERY);
    assign ctl.load  = data_vld_reg;
    assign ctl.pick  = (state_reg == PICK);

    rol_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (state_reg == SCAN),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    rol_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .query_start (req.range_start),
        .query_end   (req.range_end),
        .entry       (rd_data),
        .entry_idx   (data_idx_reg),
        .result      (scan_res)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if ((req.op == OP_QUERY) && (req.range_start < req.range_end))
                    begin
                        state_next = SCAN;
                    end
                    else
                    begin
                        state_next = RESP;
                    end
                end
            end
            SCAN:
            begin
                if (cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:   state_next = PICK;
            PICK:    state_next = JUDGE;
            JUDGE:   state_next = RESP;
            RESP:
            begin
                if (out_free)
                begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    // State, scan counter, pending result and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            data_vld_reg  <= 1'b0;
            data_idx_reg  <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            data_vld_reg <= (state_reg == SCAN);
            data_idx_reg <= cnt_reg;

            if (state_reg == SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (accept)
            begin
                res_reg.slot <= '0;
                if ((req.op == OP_QUERY) && (req.range_start >= req.range_end))
                begin
                    res_reg.status <= ST_INVALID;
                end
                else
                begin
                    res_reg.status <= ST_NONE;
                end
            end
            else if (state_reg == JUDGE)
            begin
                res_reg <= scan_res;
            end

            if ((state_reg == RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign req.ready    = (state_reg == IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_reg.status;
    assign rsp.hit_slot = out_reg.slot;

endmodule

// ===== rtl/rol_checker.sv =====
// Port-level checker for the range overlap table lookup, bound to the top level.
// Depends on rol_pkg and range_overlap_table_lookup_defines.svh.
`include "range_overlap_table_lookup_defines.svh"

module rol_checker
    import rol_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [SLOT_W-1:0]   rsp_hit_slot
);

    // A stalled response beat keeps its payload.
    `ROL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_hit_slot), "response beat changed while stalled")

    // No hit slot is reported without a hit.
    `ROL_ASSERT_NOW(a_no_hit_slot, clk, rst_n, rsp_valid && (rsp_status == ST_NONE || rsp_status == ST_INVALID), rsp_hit_slot == '0, "hit slot set without a hit")

    // Only one item is worked on at a time.
    `ROL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while another item is in flight")

    // A response beat never appears in the cycle right after a request is taken.
    `ROL_ASSERT_NEXT(a_min_latency, clk, rst_n, req_valid && req_ready && !rsp_valid, !rsp_valid, "response earlier than the minimum latency")

endmodule

bind range_overlap_table_lookup rol_checker u_rol_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_hit_slot (rsp.hit_slot)
);

// ===== dv/range_overlap_table_lookup_tb.sv =====
// Self-checking testbench for the range overlap table lookup: directed and random
// write and query beats, checked against a predictor of the range table.
// Depends on rol_pkg, the rol_in_if/rol_out_if interfaces and the block itself.
module range_overlap_table_lookup_tb
    import rol_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam addr_t ADDR_TOP     = '1;
    localparam int    RANDOM_ITEMS = 1150;
    localparam int    HOLD_CYCLES  = 500;
    localparam int    HOLD_AFTER   = 150;

    // One request beat as offered to the block.
    typedef struct packed {
        logic              op;
        addr_t             range_start;
        addr_t             range_end;
        logic [SLOT_W-1:0] slot;
        logic              slot_valid;
    } item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rol_in_if  req_ch ();
    rol_out_if rsp_ch ();

    range_overlap_table_lookup uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Source and sink state; the channel inputs follow these registers.
    item_t       offer       = '0;
    logic        offer_valid = 1'b0;
    logic        take_rsp    = 1'b0;
    int unsigned src_wait    = 0;
    int unsigned sink_wait   = 0;
    logic        src_quiet   = 1'b0;
    logic        sink_quiet  = 1'b0;
    int unsigned hold_left   = 0;
    logic        hold_used   = 1'b0;
    int unsigned rsp_seen    = 0;
    int          errors      = 0;

    item_t stim_q[$];
    res_t  verdict_q[$];

    // Predicted table contents.
    addr_t span_lo [TABLE_ENTRIES];
    addr_t span_hi [TABLE_ENTRIES];
    logic  span_on [TABLE_ENTRIES];

    // Addresses already written, used to aim random beats at existing edges.
    addr_t gen_edge [2*TABLE_ENTRIES];
    addr_t region;

    assign req_ch.valid       = offer_valid;
    assign req_ch.op          = offer.op;
    assign req_ch.range_start = offer.range_start;
    assign req_ch.range_end   = offer.range_end;
    assign req_ch.slot        = offer.slot;
    assign req_ch.slot_valid  = offer.slot_valid;
    assign rsp_ch.ready       = take_rsp;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Judge a query against an entry whose start lies at or below the query start.
    function automatic res_t judge_span(input int e, input addr_t qs, input addr_t qe);
        res_t r;
        r = '0;
        if (qe <= span_hi[e])
        begin
            r.status = ST_CONTAINED;
            r.slot   = SLOT_W'(e);
        end
        else if (qs < span_hi[e])
        begin
            r.status = ST_OVERLAP;
            r.slot   = SLOT_W'(e);
        end
        return r;
    endfunction

    // Apply one beat to the predicted table and return the response it should give.
    function automatic res_t resolve_item(input item_t it);
        res_t  r;
        addr_t qs;
        addr_t qe;
        logic  any_on;
        logic  has_up;
        logic  has_down;
        int    top;
        int    up;
        int    down;
        r        = '0;
        qs       = it.range_start;
        qe       = it.range_end;
        any_on   = 1'b0;
        has_up   = 1'b0;
        has_down = 1'b0;
        top      = 0;
        up       = 0;
        down     = 0;
        if (it.op == OP_WRITE)
        begin
            if (it.slot < TABLE_ENTRIES)
            begin
                span_lo[it.slot] = it.range_start;
                span_hi[it.slot] = it.range_end;
                span_on[it.slot] = it.slot_valid;
            end
            return r;
        end
        if (qs >= qe)
        begin
            r.status = ST_INVALID;
            return r;
        end
        // Scan for the nearest start above, the nearest below and the highest start.
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (span_on[i])
            begin
                if (!any_on || span_lo[i] > span_lo[top])
                    top = i;
                any_on = 1'b1;
                if (span_lo[i] >= qs && (!has_up || span_lo[i] < span_lo[up]))
                begin
                    up     = i;
                    has_up = 1'b1;
                end
                if (span_lo[i] <= qs && (!has_down || span_lo[i] > span_lo[down]))
                begin
                    down     = i;
                    has_down = 1'b1;
                end
            end
        end
        if (!any_on)
            return r;
        if (!has_up)
            return judge_span(top, qs, qe);
        if (span_lo[up] == qs)
            return judge_span(up, qs, qe);
        if (qe > span_lo[up])
        begin
            r.status = ST_OVERLAP;
            r.slot   = SLOT_W'(up);
            return r;
        end
        if (!has_down)
            return r;
        return judge_span(down, qs, qe);
    endfunction

    // Idle cycles before the next beat; quiet stretches bring no idling at all.
    function automatic int unsigned draw_wait(inout logic quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Address near the current region, fully random, or next to a written edge.
    function automatic addr_t pick_addr();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return region + addr_t'($urandom_range(0, 255));
        if (k < 8)
            return {$urandom, $urandom};
        return gen_edge[$urandom_range(0, 2*TABLE_ENTRIES-1)] + addr_t'($urandom_range(0, 2))
               - addr_t'(1);
    endfunction

    task automatic add_write(input int s, input addr_t lo, input addr_t hi, input logic mark);
        item_t it;
        it.op          = OP_WRITE;
        it.range_start = lo;
        it.range_end   = hi;
        it.slot        = SLOT_W'(s);
        it.slot_valid  = mark;
        gen_edge[2*s]   = lo;
        gen_edge[2*s+1] = hi;
        stim_q.push_back(it);
    endtask

    task automatic add_query(input addr_t lo, input addr_t hi);
        item_t it;
        it.op          = OP_QUERY;
        it.range_start = lo;
        it.range_end   = hi;
        it.slot        = SLOT_W'($urandom_range(0, 15));
        it.slot_valid  = 1'($urandom_range(0, 1));
        stim_q.push_back(it);
    endtask

    // Driver: offers queued beats, idling a drawn number of cycles between them.
    always @(posedge clk or negedge rst_n)
    begin : drive_p
        logic free;
        if (!rst_n)
        begin
            offer_valid <= 1'b0;
            src_wait    <= 0;
        end
        else
        begin
            free = !offer_valid;
            if (offer_valid && req_ch.ready)
            begin
                verdict_q.push_back(resolve_item(offer));
                free = 1'b1;
            end
            if (free)
            begin
                if (src_wait != 0)
                begin
                    src_wait    <= src_wait - 1;
                    offer_valid <= 1'b0;
                end
                else if (stim_q.size() != 0)
                begin
                    offer       <= stim_q.pop_front();
                    offer_valid <= 1'b1;
                    src_wait    <= draw_wait(src_quiet);
                end
                else
                begin
                    offer_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so that the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && rsp_seen >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks every response beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : collect_p
        res_t        want;
        int unsigned gap_n;
        if (!rst_n)
        begin
            take_rsp  <= 1'b0;
            sink_wait <= 0;
            rsp_seen  <= 0;
        end
        else
        begin
            gap_n = (sink_wait != 0) ? sink_wait - 1 : 0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen <= rsp_seen + 1;
                gap_n    = draw_wait(sink_quiet);
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual status %0d hit_slot %0d",
                             $time, rsp_ch.status, rsp_ch.hit_slot);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.hit_slot !== want.slot)
                    begin
                        $display("%0t: hit_slot mismatch, expected %0d actual %0d",
                                 $time, want.slot, rsp_ch.hit_slot);
                        errors++;
                    end
                end
            end
            sink_wait <= gap_n;
            take_rsp  <= (gap_n == 0) && (hold_left == 0);
        end
    end

    // Stimulus, then drain and final verdict.
    initial
    begin : stim_p
        item_t it;
        for (int i = 0; i < 2*TABLE_ENTRIES; i++)
            gen_edge[i] = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            span_lo[i] = '0;
            span_hi[i] = '0;
            span_on[i] = 1'b0;
        end
        region = '0;

        // Empty table and invalid ranges.
        add_query(64'd10, 64'd20);
        add_query(64'd5, 64'd5);
        add_query(ADDR_TOP, '0);
        // Two entries with equal starts: the lower index must win.
        add_write(0, 64'd100, 64'd200, 1'b1);
        add_write(15, 64'd100, 64'd150, 1'b1);
        add_query(64'd100, 64'd120);
        add_query(64'd150, 64'd250);
        // Query below every entry, then one reaching into the first entry.
        add_query(64'd50, 64'd60);
        add_query(64'd50, 64'd101);
        // Entry whose end is not above its start.
        add_write(7, 64'd300, 64'd250, 1'b1);
        add_query(64'd300, 64'd301);
        // Full address space and queries above every entry.
        add_write(3, '0, ADDR_TOP, 1'b1);
        add_query('0, ADDR_TOP);
        add_query(ADDR_TOP - 64'd1, ADDR_TOP);
        add_write(15, 64'd100, 64'd150, 1'b0);
        add_write(8, ADDR_TOP - 64'd15, ADDR_TOP, 1'b1);
        add_query(ADDR_TOP - 64'd7, ADDR_TOP);
        // Invalidate everything again.
        add_write(0, '0, '0, 1'b0);
        add_write(3, '0, '0, 1'b0);
        add_write(7, '0, '0, 1'b0);
        add_write(8, ADDR_TOP, ADDR_TOP, 1'b0);
        add_query(64'd1, ADDR_TOP);

        // Random part: dense ranges around a moving region so entries collide often.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: region = '0;
                    1: region = ADDR_TOP - addr_t'(511);
                    default: region = {$urandom, $urandom};
                endcase
            end
            if ($urandom_range(0, 99) < 35)
            begin
                it.range_start = pick_addr();
                if ($urandom_range(0, 9) == 0)
                    it.range_end = pick_addr();
                else
                    it.range_end = it.range_start + addr_t'($urandom_range(0, 96));
                add_write($urandom_range(0, 15), it.range_start, it.range_end,
                          $urandom_range(0, 6) != 0);
            end
            else
            begin
                it.range_start = pick_addr();
                if ($urandom_range(0, 11) == 0)
                    it.range_end = pick_addr();
                else
                    it.range_end = it.range_start + addr_t'($urandom_range(1, 120));
                add_query(it.range_start, it.range_end);
            end
        end

        while (!rst_n)
            @(posedge clk);
        while (stim_q.size() != 0 || offer_valid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
